/* rtl/arm_forward_kinematics_6dof_defines.svh */
// Assertion macros used by the RTL queue.
// Simulation gets the checks; synthesis sees nothing.
`ifndef ARM_FORWARD_KINEMATICS_6DOF_DEFINES_SVH
`define ARM_FORWARD_KINEMATICS_6DOF_DEFINES_SVH

`ifndef SYNTHESIS

// Check a condition at every clock edge out of reset
`define AFK_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("afk6: assertion failed");

// Check that a condition leads to a result in the next cycle
`define AFK_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("afk6: assertion failed");

`else

`define AFK_ASSERT(lbl, expr)
`define AFK_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

/* rtl/afk6_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package afk6_pkg;

	// Internal fixed point: Q.28 in a 34-bit signed word
	localparam int QW   = 34;
	localparam int FRAC = 28;
	localparam int JN   = 6;
	localparam int AW   = 16;
	localparam int CW   = 15;
	localparam int OW   = 16;
	localparam int CFG_SHIFT = 14;
	localparam int OUT_SHIFT = 14;

	typedef logic signed [QW-1:0] q_t;

	localparam q_t ONE       = 34'sd268435456;
	localparam q_t HALF_PI   = 34'sd421657428;
	localparam q_t HALF_PI_H = HALF_PI / 2;
	localparam q_t XP_BIAS   = 8 * HALF_PI + HALF_PI_H;

	// Taylor coefficients, truncated
	localparam q_t SIN_K7 = ONE / 5040;
	localparam q_t SIN_K5 = ONE / 120;
	localparam q_t SIN_K3 = ONE / 6;
	localparam q_t COS_K6 = ONE / 720;
	localparam q_t COS_K4 = ONE / 24;
	localparam q_t COS_K2 = ONE / 2;

	// Quadrant count range after biasing the angle
	localparam int KMAX = 15;
	localparam int KW   = 4;

	// Queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// Output rounding and clamps
	localparam q_t OUT_RND = 34'sd8192;
	localparam q_t POS_MIN = -34'sd32768;
	localparam q_t POS_MAX = 34'sd32767;
	localparam q_t ROT_MIN = -34'sd16384;
	localparam q_t ROT_MAX = 34'sd16384;

	// Register indexes
	localparam int CIW = 3;
	localparam logic [CIW-1:0] CFG_LINK_A2   = 3'd0;
	localparam logic [CIW-1:0] CFG_LINK_A3   = 3'd1;
	localparam logic [CIW-1:0] CFG_OFFSET_D1 = 3'd2;
	localparam logic [CIW-1:0] CFG_OFFSET_D4 = 3'd3;
	localparam logic [CIW-1:0] CFG_OFFSET_D5 = 3'd4;
	localparam logic [CIW-1:0] CFG_OFFSET_D6 = 3'd5;

	localparam logic signed [CW-1:0] RST_LINK_A2   = -15'sd6963;
	localparam logic signed [CW-1:0] RST_LINK_A3   = -15'sd6426;
	localparam logic signed [CW-1:0] RST_OFFSET_D1 = 15'sd2662;
	localparam logic signed [CW-1:0] RST_OFFSET_D4 = 15'sd2184;
	localparam logic signed [CW-1:0] RST_OFFSET_D5 = 15'sd1633;
	localparam logic signed [CW-1:0] RST_OFFSET_D6 = 15'sd1632;

	localparam logic signed [2*QW-1:0] PRD_HALF = 68'sd134217728;

	typedef struct packed {
		logic signed [AW-1:0] angle_j1;
		logic signed [AW-1:0] angle_j2;
		logic signed [AW-1:0] angle_j3;
		logic signed [AW-1:0] angle_j4;
		logic signed [AW-1:0] angle_j5;
		logic signed [AW-1:0] angle_j6;
	} angles_t;

	typedef struct packed {
		logic signed [OW-1:0] pos_x;
		logic signed [OW-1:0] pos_y;
		logic signed [OW-1:0] pos_z;
		logic signed [OW-1:0] rot_00;
		logic signed [OW-1:0] rot_01;
		logic signed [OW-1:0] rot_02;
		logic signed [OW-1:0] rot_10;
		logic signed [OW-1:0] rot_11;
		logic signed [OW-1:0] rot_12;
		logic signed [OW-1:0] rot_20;
		logic signed [OW-1:0] rot_21;
		logic signed [OW-1:0] rot_22;
	} pose_t;

	// Sine and cosine of all joints, joint one at index 0
	typedef struct packed {
		logic [JN-1:0][QW-1:0] sn;
		logic [JN-1:0][QW-1:0] cs;
	} trig_t;

	typedef struct packed {
		logic signed [CW-1:0] link_a2;
		logic signed [CW-1:0] link_a3;
		logic signed [CW-1:0] offset_d1;
		logic signed [CW-1:0] offset_d4;
		logic signed [CW-1:0] offset_d5;
		logic signed [CW-1:0] offset_d6;
	} cfg_t;

	// Q.28 product, rounded half up with floor shift
	function automatic q_t fmul(input q_t a, input q_t b);
		logic signed [2*QW-1:0] p;
		p = (2*QW)'(a) * (2*QW)'(b) + PRD_HALF;
		return q_t'(p >>> FRAC);
	endfunction

	// Q1.14 register value to Q.28
	function automatic q_t cfg_to_q(input logic signed [CW-1:0] v);
		q_t w;
		w = q_t'(v);
		return w <<< CFG_SHIFT;
	endfunction

endpackage
`default_nettype wire

/* rtl/afk6_in_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface afk6_in_if import afk6_pkg::*; ();
	logic    valid;
	logic    ready;
	angles_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/afk6_out_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface afk6_out_if import afk6_pkg::*; ();
	logic  valid;
	logic  ready;
	pose_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/arm_forward_kinematics_6dof.sv */
`timescale 1ns / 1ps
`default_nettype none
// Six-axis forward kinematics: each input beat carries six joint angles (Q4.12 rad) and yields
// one output beat with the tool position (Q2.14 m, saturated) and 3x3 orientation (Q2.14).
// The block takes one joint vector per clock and keeps that rate as long as the output side
// accepts. A beat passes the per-joint sine/cosine pipelines (range reduction, then one
// multiplier per Horner step), the queue that parts them from the back end, and the back
// end (one stage per matrix product, one for rounding into the output register). The queue
// holds four vectors, so either side may stall without stopping the other at once. Link
// lengths and offsets are to be written by the user through the cfg port only while no beat
// is in flight; the block itself does not enforce this. They reset to the package values.
module arm_forward_kinematics_6dof import afk6_pkg::*; (
	input  wire logic           clk,
	input  wire logic           arst_n,
	afk6_in_if.sink             in_ch,
	afk6_out_if.source          out_ch,
	input  wire logic           cfg_we,
	input  wire logic [CIW-1:0] cfg_index,
	input  wire logic [CW-1:0]  cfg_data
);

	cfg_t  cfg_q;
	logic  push_valid, push_ready, pop_valid, pop_ready;
	trig_t push_data, pop_data;

	// Geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_a2   <= RST_LINK_A2;
			cfg_q.link_a3   <= RST_LINK_A3;
			cfg_q.offset_d1 <= RST_OFFSET_D1;
			cfg_q.offset_d4 <= RST_OFFSET_D4;
			cfg_q.offset_d5 <= RST_OFFSET_D5;
			cfg_q.offset_d6 <= RST_OFFSET_D6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LINK_A2:   cfg_q.link_a2   <= cfg_data;
				CFG_LINK_A3:   cfg_q.link_a3   <= cfg_data;
				CFG_OFFSET_D1: cfg_q.offset_d1 <= cfg_data;
				CFG_OFFSET_D4: cfg_q.offset_d4 <= cfg_data;
				CFG_OFFSET_D5: cfg_q.offset_d5 <= cfg_data;
				CFG_OFFSET_D6: cfg_q.offset_d6 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	afk6_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	afk6_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	afk6_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.cfg       (cfg_q),
		.out_ch    (out_ch)
	);

endmodule
`default_nettype wire

/* rtl/afk6_sincos.sv */
`timescale 1ns / 1ps
`default_nettype none
module afk6_sincos import afk6_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire logic signed [AW-1:0] angle,
	output q_t                        sn,
	output q_t                        cs
);

	logic [KMAX-1:0] th;
	q_t xw, xp, kq;

	q_t xp_s1;
	logic [KW-1:0] k_s1;
	q_t r_s2;
	logic [1:0] quad_s2;
	q_t r_s3, r2_s3;
	logic [1:0] quad_s3;
	q_t r_s4, r2_s4, t1_s4, u1_s4;
	logic [1:0] quad_s4;
	q_t r_s5, r2_s5, t2_s5, u2_s5;
	logic [1:0] quad_s5;
	q_t r_s6, t3_s6, c_s6;
	logic [1:0] quad_s6;
	q_t s_s7, c_s7;
	logic [1:0] quad_s7;

	// Bias the angle positive and count whole quarter turns
	always_comb begin
		xw = q_t'(angle);
		xp = (xw <<< 16) + XP_BIAS;
		for (int m = 0; m < KMAX; m++) begin
			th[m] = xp >= q_t'(m + 1) * HALF_PI;
		end
		kq = q_t'(k_s1);
	end

	// Range reduction, then Horner steps of both polynomials
	always_ff @(posedge clk) begin
		if (en) begin
			xp_s1   <= xp;
			k_s1    <= KW'($countones(th));
			r_s2    <= xp_s1 - kq * HALF_PI - HALF_PI_H;
			quad_s2 <= k_s1[1:0];
			r_s3    <= r_s2;
			r2_s3   <= fmul(r_s2, r_s2);
			quad_s3 <= quad_s2;
			r_s4    <= r_s3;
			r2_s4   <= r2_s3;
			t1_s4   <= SIN_K5 - fmul(r2_s3, SIN_K7);
			u1_s4   <= COS_K4 - fmul(r2_s3, COS_K6);
			quad_s4 <= quad_s3;
			r_s5    <= r_s4;
			r2_s5   <= r2_s4;
			t2_s5   <= SIN_K3 - fmul(r2_s4, t1_s4);
			u2_s5   <= COS_K2 - fmul(r2_s4, u1_s4);
			quad_s5 <= quad_s4;
			r_s6    <= r_s5;
			t3_s6   <= ONE - fmul(r2_s5, t2_s5);
			c_s6    <= ONE - fmul(r2_s5, u2_s5);
			quad_s6 <= quad_s5;
			s_s7    <= fmul(r_s6, t3_s6);
			c_s7    <= c_s6;
			quad_s7 <= quad_s6;
		end
	end

	// Rotate the result into the right quadrant
	always_comb begin
		case (quad_s7)
			2'd0: begin
				sn = s_s7;
				cs = c_s7;
			end
			2'd1: begin
				sn = c_s7;
				cs = -s_s7;
			end
			2'd2: begin
				sn = -s_s7;
				cs = -c_s7;
			end
			default: begin
				sn = -c_s7;
				cs = s_s7;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/afk6_front.sv */
`timescale 1ns / 1ps
`default_nettype none
module afk6_front import afk6_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	afk6_in_if.sink    in_ch,
	output logic       push_valid,
	input  wire logic  push_ready,
	output trig_t      push_data
);

	localparam int FD = 7;

	logic          en;
	logic [FD-1:0] vld_q;
	logic [JN-1:0][AW-1:0] ang;
	q_t            sn [JN];
	q_t            cs [JN];

	// Advance unless the last stage holds a beat the queue cannot take
	assign en           = !vld_q[FD-1] || push_ready;
	assign in_ch.ready  = en;
	assign push_valid   = vld_q[FD-1];

	assign ang[0] = in_ch.data.angle_j1;
	assign ang[1] = in_ch.data.angle_j2;
	assign ang[2] = in_ch.data.angle_j3;
	assign ang[3] = in_ch.data.angle_j4;
	assign ang[4] = in_ch.data.angle_j5;
	assign ang[5] = in_ch.data.angle_j6;

	// Track which stages hold a beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[FD-2:0], in_ch.valid};
		end
	end

	// One sine/cosine lane per joint
	for (genvar j = 0; j < JN; j++) begin : g_lane
		afk6_sincos u_sincos (
			.clk   (clk),
			.en    (en),
			.angle (signed'(ang[j])),
			.sn    (sn[j]),
			.cs    (cs[j])
		);
		assign push_data.sn[j] = sn[j];
		assign push_data.cs[j] = cs[j];
	end

endmodule
`default_nettype wire

/* rtl/afk6_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "arm_forward_kinematics_6dof_defines.svh"
module afk6_queue import afk6_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push_valid,
	output logic       push_ready,
	input  wire trig_t push_data,
	output logic       pop_valid,
	input  wire logic  pop_ready,
	output trig_t      pop_data
);

	trig_t            mem_q [QDEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QCW-1:0]   cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != QCW'(QDEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_q];

	// Store incoming beats
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`AFK_ASSERT(a_cnt_bound, cnt_q <= QCW'(QDEPTH))
	`AFK_ASSERT_NEXT(a_cnt_up, push && !pop, cnt_q == $past(cnt_q) + 1'b1)
	`AFK_ASSERT_NEXT(a_cnt_down, pop && !push, cnt_q == $past(cnt_q) - 1'b1)
	`AFK_ASSERT_NEXT(a_ptr_gap, push || pop, QPW'(wr_q - rd_q) == QPW'(cnt_q))

endmodule
`default_nettype wire

/* rtl/afk6_back.sv */
`timescale 1ns / 1ps
`default_nettype none
module afk6_back import afk6_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  pop_valid,
	output logic       pop_ready,
	input  wire trig_t pop_data,
	input  wire cfg_t  cfg,
	afk6_out_if.source out_ch
);

	localparam int BD = 6;

	logic          en;
	logic [BD-1:0] vld_q;

	q_t j1m [3][4];
	q_t acc_n1 [3][4], acc_n2 [3][4], acc_n3 [3][4], acc_n4 [3][4], acc_n5 [3][4];
	q_t acc_b1 [3][4], acc_b2 [3][4], acc_b3 [3][4], acc_b4 [3][4], acc_b5 [3][4];
	trig_t trig_b1, trig_b2, trig_b3, trig_b4;
	pose_t pose_n, pose_b6;

	q_t c1, s1, c2, s2, c3, s3, c4, s4, c5, s5, c6, s6;
	q_t a2q, a3q, d1q, d4q, d5q, d6q;

	function automatic logic signed [OW-1:0] to_out(input q_t v, input q_t lo, input q_t hi);
		q_t t;
		t = (v + OUT_RND) >>> OUT_SHIFT;
		if (t < lo) begin
			t = lo;
		end
		if (t > hi) begin
			t = hi;
		end
		return t[OW-1:0];
	endfunction

	assign en            = !vld_q[BD-1] || out_ch.ready;
	assign pop_ready     = en;
	assign out_ch.valid  = vld_q[BD-1];
	assign out_ch.data   = pose_b6;

	assign c1 = pop_data.cs[0];
	assign s1 = pop_data.sn[0];
	assign c2 = pop_data.cs[1];
	assign s2 = pop_data.sn[1];
	assign c3 = trig_b1.cs[2];
	assign s3 = trig_b1.sn[2];
	assign c4 = trig_b2.cs[3];
	assign s4 = trig_b2.sn[3];
	assign c5 = trig_b3.cs[4];
	assign s5 = trig_b3.sn[4];
	assign c6 = trig_b4.cs[5];
	assign s6 = trig_b4.sn[5];

	assign a2q = cfg_to_q(cfg.link_a2);
	assign a3q = cfg_to_q(cfg.link_a3);
	assign d1q = cfg_to_q(cfg.offset_d1);
	assign d4q = cfg_to_q(cfg.offset_d4);
	assign d5q = cfg_to_q(cfg.offset_d5);
	assign d6q = cfg_to_q(cfg.offset_d6);

	// Joint one transform times joint two
	always_comb begin
		j1m[0][0] = c1;
		j1m[0][1] = -s1;
		j1m[0][2] = '0;
		j1m[0][3] = '0;
		j1m[1][0] = s1;
		j1m[1][1] = c1;
		j1m[1][2] = '0;
		j1m[1][3] = '0;
		j1m[2][0] = '0;
		j1m[2][1] = '0;
		j1m[2][2] = ONE;
		j1m[2][3] = d1q;
		for (int i = 0; i < 3; i++) begin
			acc_n1[i][0] = fmul(j1m[i][0], c2) + fmul(j1m[i][2], s2);
			acc_n1[i][1] = fmul(j1m[i][0], -s2) + fmul(j1m[i][2], c2);
			acc_n1[i][2] = -j1m[i][1];
			acc_n1[i][3] = j1m[i][3];
		end
	end

	// Times joint three
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_n2[i][0] = fmul(acc_b1[i][0], c3) + fmul(acc_b1[i][1], s3);
			acc_n2[i][1] = fmul(acc_b1[i][0], -s3) + fmul(acc_b1[i][1], c3);
			acc_n2[i][2] = acc_b1[i][2];
			acc_n2[i][3] = fmul(acc_b1[i][0], a2q) + acc_b1[i][3];
		end
	end

	// Times joint four
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_n3[i][0] = fmul(acc_b2[i][0], c4) + fmul(acc_b2[i][1], s4);
			acc_n3[i][1] = fmul(acc_b2[i][0], -s4) + fmul(acc_b2[i][1], c4);
			acc_n3[i][2] = acc_b2[i][2];
			acc_n3[i][3] = fmul(acc_b2[i][0], a3q) + fmul(acc_b2[i][2], d4q)
				+ acc_b2[i][3];
		end
	end

	// Times joint five
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_n4[i][0] = fmul(acc_b3[i][0], c5) + fmul(acc_b3[i][2], s5);
			acc_n4[i][1] = fmul(acc_b3[i][0], -s5) + fmul(acc_b3[i][2], c5);
			acc_n4[i][2] = -acc_b3[i][1];
			acc_n4[i][3] = fmul(acc_b3[i][1], -d5q) + acc_b3[i][3];
		end
	end

	// Times joint six
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			acc_n5[i][0] = fmul(acc_b4[i][0], c6) + fmul(acc_b4[i][2], -s6);
			acc_n5[i][1] = fmul(acc_b4[i][0], -s6) + fmul(acc_b4[i][2], -c6);
			acc_n5[i][2] = acc_b4[i][1];
			acc_n5[i][3] = fmul(acc_b4[i][1], d6q) + acc_b4[i][3];
		end
	end

	// Round and clamp the pose
	always_comb begin
		pose_n.pos_x  = to_out(acc_b5[0][3], POS_MIN, POS_MAX);
		pose_n.pos_y  = to_out(acc_b5[1][3], POS_MIN, POS_MAX);
		pose_n.pos_z  = to_out(acc_b5[2][3], POS_MIN, POS_MAX);
		pose_n.rot_00 = to_out(acc_b5[0][0], ROT_MIN, ROT_MAX);
		pose_n.rot_01 = to_out(acc_b5[0][1], ROT_MIN, ROT_MAX);
		pose_n.rot_02 = to_out(acc_b5[0][2], ROT_MIN, ROT_MAX);
		pose_n.rot_10 = to_out(acc_b5[1][0], ROT_MIN, ROT_MAX);
		pose_n.rot_11 = to_out(acc_b5[1][1], ROT_MIN, ROT_MAX);
		pose_n.rot_12 = to_out(acc_b5[1][2], ROT_MIN, ROT_MAX);
		pose_n.rot_20 = to_out(acc_b5[2][0], ROT_MIN, ROT_MAX);
		pose_n.rot_21 = to_out(acc_b5[2][1], ROT_MIN, ROT_MAX);
		pose_n.rot_22 = to_out(acc_b5[2][2], ROT_MIN, ROT_MAX);
	end

	// Track which stages hold a beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[BD-2:0], pop_valid};
		end
	end

	// Advance the matrix chain
	always_ff @(posedge clk) begin
		if (en) begin
			acc_b1  <= acc_n1;
			trig_b1 <= pop_data;
			acc_b2  <= acc_n2;
			trig_b2 <= trig_b1;
			acc_b3  <= acc_n3;
			trig_b3 <= trig_b2;
			acc_b4  <= acc_n4;
			trig_b4 <= trig_b3;
			acc_b5  <= acc_n5;
			pose_b6 <= pose_n;
		end
	end

endmodule
`default_nettype wire
